@@ rtl/core/tunnel_texel_fog_shader_unit_assert.svh @@
// assertion macros for the tunnel texel fog shader checker
// expects clk in the scope of every use, and rst_n for TTFS_ASSERT
`ifndef TUNNEL_TEXEL_FOG_SHADER_UNIT_ASSERT_SVH
`define TUNNEL_TEXEL_FOG_SHADER_UNIT_ASSERT_SVH

// clocked assertion, switched off while reset is low
`define TTFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define TTFS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/ttfs_pkg.sv @@
// shared types and constants of the tunnel texel fog shader
// no dependencies
package ttfs_pkg;

  // input transaction kinds
  localparam logic [1:0] KIND_TEX_WR = 2'd0;
  localparam logic [1:0] KIND_PAL_WR = 2'd1;
  localparam logic [1:0] KIND_PIXEL  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_TEX_SIZE = 2'd0;
  localparam logic [1:0] CFG_SCROLL   = 2'd1;
  localparam logic [1:0] CFG_BLUR     = 2'd2;

  localparam int PAL_DEPTH = 256;
  localparam int Q_DEPTH   = 4;
  localparam int FOG_LEVELS = 16;

  // fog colour, red / green / blue
  localparam logic [7:0] FOG_END [3] = '{8'd50, 8'd0, 8'd50};

  // floor((level << 16) / (FOG_LEVELS - 1))
  localparam logic [16:0] FOG_WEIGHT [FOG_LEVELS] = '{
    17'd0,     17'd4369,  17'd8738,  17'd13107,
    17'd17476, 17'd21845, 17'd26214, 17'd30583,
    17'd34952, 17'd39321, 17'd43690, 17'd48059,
    17'd52428, 17'd56797, 17'd61166, 17'd65536
  };

  // classified operation carried from front to back
  typedef enum logic [1:0] {
    OP_TEX_WR,
    OP_PAL_WR,
    OP_PIXEL
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  fog;
    logic [23:0] data;
  } cmd_t;

endpackage

@@ rtl/core/ttfs_ram.sv @@
// generic single port ram with registered read and read/write enable
// no dependencies
module ttfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read, both held while en is low
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/ttfs_front.sv @@
// front end: configuration registers, input classification and texel address
// depends on ttfs_pkg
module ttfs_front #(
  parameter int MAX_TEX_LOG2 = 8,
  parameter int BLUR_COPIES  = 4,
  parameter int TEX_AW       = 18
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [17:0]        in_load_index,
  input  logic [23:0]        in_load_value,
  input  logic [31:0]        in_tex_coord,
  input  logic [7:0]         in_fog_amount,
  input  logic               q_full,
  output logic               push,
  output ttfs_pkg::cmd_t     push_cmd,
  output logic [TEX_AW-1:0]  push_addr
);
  import ttfs_pkg::*;

  localparam int SW        = $clog2(MAX_TEX_LOG2 + 1);
  localparam int LW        = (BLUR_COPIES > 1) ? $clog2(BLUR_COPIES) : 1;
  localparam int TEX_DEPTH = BLUR_COPIES << (2 * MAX_TEX_LOG2);

  logic [3:0]  tex_size_r;
  logic [15:0] scroll_r;
  logic [1:0]  blur_r;

  logic [SW-1:0]     s;
  logic [LW-1:0]     lvl;
  logic [4:0]        shift;
  logic [15:0]       mask;
  logic [15:0]       tx;
  logic [15:0]       ty;
  logic [TEX_AW-1:0] pix_addr;
  logic              keep;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_size_r <= 4'd8;
      scroll_r   <= 16'd0;
      blur_r     <= 2'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TEX_SIZE: tex_size_r <= cfg_wdata[3:0];
        CFG_SCROLL:   scroll_r   <= cfg_wdata;
        CFG_BLUR:     blur_r     <= cfg_wdata[1:0];
        default:      ;
      endcase
    end
  end

  // saturated size and blur copy
  always_comb begin
    priority if (tex_size_r == 4'd0) begin
      s = SW'(1);
    end else if (32'(tex_size_r) > MAX_TEX_LOG2) begin
      s = SW'(MAX_TEX_LOG2);
    end else begin
      s = SW'(tex_size_r);
    end
    if (32'(blur_r) >= BLUR_COPIES) begin
      lvl = LW'(BLUR_COPIES - 1);
    end else begin
      lvl = LW'(blur_r);
    end
  end

  // top bits of u and v, scroll, wrap and address
  always_comb begin
    shift    = 5'd16 - 5'(s);
    mask     = (16'd1 << s) - 16'd1;
    tx       = (in_tex_coord[31:16] >> shift) & mask;
    ty       = ((in_tex_coord[15:0] >> shift) + scroll_r) & mask;
    pix_addr = (TEX_AW'(lvl) << {s, 1'b0}) | (TEX_AW'(ty) << s) | TEX_AW'(tx);
  end

  // classification; out of range writes and the unused kind are dropped
  always_comb begin
    push_cmd.fog  = in_fog_amount;
    push_cmd.data = in_load_value;
    push_cmd.op   = OP_PIXEL;
    push_addr     = pix_addr;
    keep          = 1'b0;
    unique case (in_kind)
      KIND_TEX_WR: begin
        push_cmd.op = OP_TEX_WR;
        push_addr   = TEX_AW'(in_load_index);
        keep        = 32'(in_load_index) < TEX_DEPTH;
      end
      KIND_PAL_WR: begin
        push_cmd.op = OP_PAL_WR;
        push_addr   = TEX_AW'(in_load_index[7:0]);
        keep        = in_load_index[17:8] == 10'd0;
      end
      KIND_PIXEL: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full && keep;

endmodule

@@ rtl/core/ttfs_cmd_queue.sv @@
// short command queue between front and back ends
// depends on ttfs_pkg
module ttfs_cmd_queue #(
  parameter int ADDR_W = 18
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ttfs_pkg::cmd_t     push_cmd,
  input  logic [ADDR_W-1:0]  push_addr,
  output logic               q_full,
  output logic               q_valid,
  input  logic               pop,
  output ttfs_pkg::cmd_t     head_cmd,
  output logic [ADDR_W-1:0]  head_addr
);
  import ttfs_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  cmd_t              cmd_q   [Q_DEPTH];
  logic [ADDR_W-1:0] addr_q  [Q_DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[wr_ptr_r]  <= push_cmd;
      addr_q[wr_ptr_r] <= push_addr;
    end
  end

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  assign q_full    = count_r == CW'(Q_DEPTH);
  assign q_valid   = count_r != '0;
  assign head_cmd  = cmd_q[rd_ptr_r];
  assign head_addr = addr_q[rd_ptr_r];

endmodule

@@ rtl/core/ttfs_back.sv @@
// back end: texture and palette access, fog blend, rgb565 output register
// depends on ttfs_pkg and ttfs_ram
module ttfs_back #(
  parameter int MAX_TEX_LOG2 = 8,
  parameter int BLUR_COPIES  = 4,
  parameter int TEX_AW       = 18
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ttfs_pkg::cmd_t     head_cmd,
  input  logic [TEX_AW-1:0]  head_addr,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_pixel_color
);
  import ttfs_pkg::*;

  localparam int TEX_DEPTH = BLUR_COPIES << (2 * MAX_TEX_LOG2);

  logic        advance;
  logic [7:0]  tex_rdata;
  logic [23:0] pal_rdata;
  logic [7:0]  pal_addr;

  logic        p1_valid_r;
  op_t         p1_op_r;
  logic [7:0]  p1_pal_idx_r;
  logic [23:0] p1_data_r;
  logic [7:0]  p1_fog_r;

  logic        p2_valid_r;
  logic [7:0]  p2_fog_r;

  logic               p3_valid_r;
  logic [7:0]         p3_chan_r [3];
  logic signed [26:0] p3_prod_r [3];

  logic [7:0]         chan      [3];
  logic signed [26:0] prod_nxt  [3];
  logic [7:0]         res       [3];
  logic [15:0]        color_nxt;

  logic        out_valid_r;
  logic [15:0] out_color_r;

  // whole back pipeline moves when the output register can take a result
  assign advance = !out_valid_r || !out_stall;
  assign pop     = advance && q_valid;

  // texture read or write at the queue head
  ttfs_ram #(
    .WIDTH (8),
    .DEPTH (TEX_DEPTH)
  ) u_tex_ram (
    .clk   (clk),
    .en    (advance),
    .we    (pop && head_cmd.op == OP_TEX_WR),
    .addr  (head_addr),
    .wdata (head_cmd.data[7:0]),
    .rdata (tex_rdata)
  );

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (advance) begin
      p1_valid_r <= pop && head_cmd.op != OP_TEX_WR;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_op_r      <= head_cmd.op;
      p1_pal_idx_r <= head_addr[7:0];
      p1_data_r    <= head_cmd.data;
      p1_fog_r     <= head_cmd.fog;
    end
  end

  // palette access in order with pixels: texel index or write index
  assign pal_addr = (p1_op_r == OP_PIXEL) ? tex_rdata : p1_pal_idx_r;

  ttfs_ram #(
    .WIDTH (24),
    .DEPTH (PAL_DEPTH)
  ) u_pal_ram (
    .clk   (clk),
    .en    (advance),
    .we    (p1_valid_r && p1_op_r == OP_PAL_WR),
    .addr  (pal_addr),
    .wdata (p1_data_r),
    .rdata (pal_rdata)
  );

  // stage 2 registers, pixels only from here on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else if (advance) begin
      p2_valid_r <= p1_valid_r && p1_op_r == OP_PIXEL;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p2_fog_r <= p1_fog_r;
    end
  end

  // fog products (end - c) * weight per channel
  always_comb begin
    chan[0] = pal_rdata[23:16];
    chan[1] = pal_rdata[15:8];
    chan[2] = pal_rdata[7:0];
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = 27'(($signed({1'b0, FOG_END[i]}) - $signed({1'b0, chan[i]}))
                    * $signed({1'b0, FOG_WEIGHT[p2_fog_r[7:4]]}));
    end
  end

  // stage 3 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_valid_r <= 1'b0;
    end else if (advance) begin
      p3_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p3_chan_r <= chan;
      p3_prod_r <= prod_nxt;
    end
  end

  // floor shift by 16 and add; only the low byte of the delta matters
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res[i] = p3_chan_r[i] + p3_prod_r[i][23:16];
    end
    color_nxt = {res[0][7:3], res[1][7:2], res[2][7:3]};
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= p3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_color_r <= color_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_color_r;

endmodule

@@ rtl/core/tunnel_texel_fog_shader_unit.sv @@
// top level of the tunnel texel fog shader
// depends on ttfs_pkg, ttfs_front, ttfs_cmd_queue, ttfs_back
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  kind, load index/value, coord, fog
//  out      output     out_valid/out_stall pixel_color (rgb565)
//  cfg      input      cfg_wr_en          cfg_index, cfg_wdata
//
// one transaction per clock while in_stall is low; a pixel result passes from the queue through
// the texture ram read, palette ram read, fog multiply and add into the output register
// writes take the same path and give no result
// reset is synchronous and clears the queue, the pipeline and the configuration
// out_stall freezes the back pipeline; the four entry queue keeps taking input
// until full, and in_stall follows only the queue fill
module tunnel_texel_fog_shader_unit #(
  parameter int MAX_TEX_LOG2 = 8,
  parameter int BLUR_COPIES  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [17:0] in_load_index,
  input  logic [23:0] in_load_value,
  input  logic [31:0] in_tex_coord,
  input  logic [7:0]  in_fog_amount,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pixel_color
);
  import ttfs_pkg::*;

  localparam int TEX_AW = $clog2(BLUR_COPIES << (2 * MAX_TEX_LOG2));

  logic              q_full;
  logic              q_valid;
  logic              push;
  logic              pop;
  cmd_t              push_cmd;
  cmd_t              head_cmd;
  logic [TEX_AW-1:0] push_addr;
  logic [TEX_AW-1:0] head_addr;

  // accept and classify
  ttfs_front #(
    .MAX_TEX_LOG2 (MAX_TEX_LOG2),
    .BLUR_COPIES  (BLUR_COPIES),
    .TEX_AW       (TEX_AW)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_load_index (in_load_index),
    .in_load_value (in_load_value),
    .in_tex_coord  (in_tex_coord),
    .in_fog_amount (in_fog_amount),
    .q_full        (q_full),
    .push          (push),
    .push_cmd      (push_cmd),
    .push_addr     (push_addr)
  );

  // decoupling queue
  ttfs_cmd_queue #(
    .ADDR_W (TEX_AW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_addr (push_addr),
    .q_full    (q_full),
    .q_valid   (q_valid),
    .pop       (pop),
    .head_cmd  (head_cmd),
    .head_addr (head_addr)
  );

  // memories, blend and result
  ttfs_back #(
    .MAX_TEX_LOG2 (MAX_TEX_LOG2),
    .BLUR_COPIES  (BLUR_COPIES),
    .TEX_AW       (TEX_AW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .head_cmd        (head_cmd),
    .head_addr       (head_addr),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_color (out_pixel_color)
  );

endmodule

@@ rtl/core/ttfs_checker.sv @@
// port level checker for the tunnel texel fog shader, bound to the top level
// depends on ttfs_pkg and tunnel_texel_fog_shader_unit_assert.svh
`include "tunnel_texel_fog_shader_unit_assert.svh"

module ttfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_kind,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_pixel_color
);
  import ttfs_pkg::*;

  // a stalled result stays and holds its colour
  `TTFS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_pixel_color), "stalled result changed")

  // reset leaves no result pending and the input open
  `TTFS_ASSERT_RST(a_reset_clear, !rst_n |=> !out_valid && !in_stall, "state left after reset")

  // the queue only fills through an accepted transaction of a known kind
  `TTFS_ASSERT(a_stall_rise, $rose(in_stall) |-> $past(in_valid && !in_stall && (in_kind != KIND_NONE)), "in_stall rose without a push")

endmodule

bind tunnel_texel_fog_shader_unit ttfs_checker u_ttfs_checker (.*);
